FILE: hdl/npve_pkg.sv
package npve_pkg;

  localparam int TIMER_BITS_DEF = 24;

  localparam int NOTE_COUNT     = 13;
  localparam int PITCH_ATTACK_US = 200000;
  localparam int VOL_FADE_US    = 100000;
  localparam int FLUSH_DELAY_US = 1000000;
  localparam int FLUSH_SPAN_US  = 6000000;
  localparam int FLUSH_END_US   = FLUSH_DELAY_US + FLUSH_SPAN_US;
  localparam int TOUCH_MAX      = 1023;
  localparam int VOL_MAX        = 255;
  localparam int HZ_BASE        = 87;
  localparam int HZ_SPAN        = 175 - 87;
  localparam int FLUSH_ONE      = 256;

  // Operand and product widths of the shared multiply/divide unit.
  localparam int MD_W  = 24;
  localparam int MD_PW = 2 * MD_W;
  localparam int MD_CW = $clog2(MD_PW);

  typedef struct packed {
    logic            start;
    logic [MD_W-1:0] a;
    logic [MD_W-1:0] b;
    logic [MD_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MD_PW-1:0] q;
  } md_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HZ,
    ST_SEARCH,
    ST_FDIV,
    ST_PB,
    ST_RED,
    ST_VY,
    ST_VOL,
    ST_FLUSH,
    ST_CHEEK,
    ST_OUT
  } npve_state_t;

  function automatic logic [7:0] note_freq(input logic [3:0] i);
    logic [7:0] f;
    case (i)
      4'd0:    f = 8'd87;
      4'd1:    f = 8'd93;
      4'd2:    f = 8'd98;
      4'd3:    f = 8'd104;
      4'd4:    f = 8'd110;
      4'd5:    f = 8'd117;
      4'd6:    f = 8'd123;
      4'd7:    f = 8'd131;
      4'd8:    f = 8'd139;
      4'd9:    f = 8'd147;
      4'd10:   f = 8'd156;
      4'd11:   f = 8'd165;
      4'd12:   f = 8'd175;
      default: f = 8'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: hdl/npve_muldiv.sv
// Computes floor(a * b / d): shift-add multiply, one bit of b per cycle, then
// a restoring divide, one quotient bit per cycle.
module npve_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  npve_pkg::md_req_t req,
  output npve_pkg::md_rsp_t rsp
);
  import npve_pkg::*;

  logic             busy;
  logic             div_phase;
  logic             done;
  logic [MD_CW-1:0] cnt;
  logic [MD_PW-1:0] acc;
  logic [MD_PW-1:0] ma;
  logic [MD_W-1:0]  mb;
  logic [MD_W-1:0]  dv;
  logic [MD_W-1:0]  rem;
  logic [MD_W:0]    trial;
  logic             ge;

  assign trial = {rem, acc[MD_PW-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      div_phase <= 1'b0;
      done      <= 1'b0;
      cnt       <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy      <= 1'b1;
        div_phase <= 1'b0;
        cnt       <= '0;
      end else if (busy) begin
        if (!div_phase) begin
          if (cnt == MD_CW'(MD_W - 1)) begin
            div_phase <= 1'b1;
            cnt       <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end else begin
          if (cnt == MD_CW'(MD_PW - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      acc <= '0;
      ma  <= {{MD_W{1'b0}}, req.a};
      mb  <= req.b;
      dv  <= req.d;
      rem <= '0;
    end else if (busy) begin
      if (!div_phase) begin
        if (mb[0]) begin
          acc <= acc + ma;
        end
        ma <= {ma[MD_PW-2:0], 1'b0};
        mb <= {1'b0, mb[MD_W-1:1]};
      end else begin
        // The product shifts out at the top while quotient bits enter below.
        rem <= ge ? MD_W'(trial - {1'b0, dv}) : trial[MD_W-1:0];
        acc <= {acc[MD_PW-2:0], ge};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.q    = acc;

endmodule

FILE: hdl/note_pitch_volume_envelope.sv
// Eight operations run in turn through one shared unit, each made of a launch, 24 multiply
// steps, 48 divide steps and done, plus a note search over 13 table entries and one output
// load. A new word is taken only once the last result is loaded, so a stalled output holds
// the input off.
// Reset: synchronous, active high; control, config and frame registers reset, data does not.
module note_pitch_volume_envelope #(
  parameter int TIMER_BITS = npve_pkg::TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // elapsed_us[19:0], dir_buttons[23:20], touch_valid[24], touch_x[34:25],
  // touch_y[44:35], zero pad [47:45]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // freq_hz[10:0], volume[18:11], note_index[22:19], octave[25:23],
  // cheek_level[33:26], zero pad [39:34]
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import npve_pkg::*;

  npve_state_t state, state_next;
  logic        launch, launch_next;

  logic [7:0]  min_volume;
  logic [6:0]  bend_percent;

  logic [TIMER_BITS-1:0] timer;
  logic [2:0]  held_octave;
  logic [9:0]  last_x;
  logic [9:0]  last_y;
  logic [10:0] last_freq;
  logic [8:0]  flush_rate;

  logic [7:0]  hz;
  logic [7:0]  best;
  logic [3:0]  idx;
  logic [3:0]  si;
  logic [3:0]  fdiv;
  logic [10:0] pb;
  logic [7:0]  vy;
  logic [7:0]  vol;
  logic [7:0]  cheek;

  logic [10:0] o_freq;
  logic [7:0]  o_vol;
  logic [3:0]  o_idx;
  logic [2:0]  o_oct;
  logic [7:0]  o_cheek;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic        accept;
  logic [19:0] in_el;
  logic [3:0]  in_btn;
  logic [2:0]  in_oct;
  logic [TIMER_BITS:0]   tsum;
  logic [TIMER_BITS-1:0] tsat;

  logic        lt200k, lt100k, le1m, ge7m;
  logic [1:0]  oshift;
  logic [10:0] fshift;
  logic [7:0]  vfloor;
  logic [7:0]  tv;
  logic [7:0]  d_new, d_best;
  logic [10:0] red;
  logic        out_load;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {25'd0, bend_percent} : {24'd0, min_volume};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_volume   <= 8'd10;
      bend_percent <= 7'd15;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        bend_percent <= pwdata[6:0];
      end else begin
        min_volume <= pwdata[7:0];
      end
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_el    = s_tdata[19:0];
  assign in_btn   = s_tdata[23:20];

  always_comb begin
    if (in_btn[0])      in_oct = 3'd1;
    else if (in_btn[1]) in_oct = 3'd2;
    else if (in_btn[2]) in_oct = 3'd3;
    else if (in_btn[3]) in_oct = 3'd4;
    else                in_oct = 3'd0;
  end

  assign tsum = {1'b0, timer} + (TIMER_BITS + 1)'(in_el);
  assign tsat = tsum[TIMER_BITS] ? '1 : tsum[TIMER_BITS-1:0];

  assign lt200k = timer <  TIMER_BITS'(PITCH_ATTACK_US);
  assign lt100k = timer <  TIMER_BITS'(VOL_FADE_US);
  assign le1m   = timer <= TIMER_BITS'(FLUSH_DELAY_US);
  assign ge7m   = timer >= TIMER_BITS'(FLUSH_END_US);

  assign oshift = (held_octave == 3'd0) ? 2'd0 : 2'(held_octave - 3'd1);
  assign fshift = {3'd0, hz} << oshift;
  assign vfloor = (vy < min_volume) ? min_volume : vy;
  assign red    = md_rsp.q[10:0];

  assign tv     = note_freq(si);
  assign d_new  = (hz > tv) ? hz - tv : tv - hz;
  assign d_best = (hz > best) ? hz - best : best - hz;

  // Operand selection for the shared unit.
  always_comb begin
    md_req.start = launch;
    md_req.a     = '0;
    md_req.b     = MD_W'(1);
    md_req.d     = MD_W'(1);
    case (state)
      ST_HZ: begin
        md_req.a = MD_W'(last_x);
        md_req.b = MD_W'(HZ_SPAN);
        md_req.d = MD_W'(TOUCH_MAX);
      end
      ST_FDIV: begin
        md_req.a = MD_W'(fshift);
        md_req.d = MD_W'(100);
      end
      ST_PB: begin
        md_req.a = MD_W'(fdiv);
        md_req.b = MD_W'(bend_percent);
      end
      ST_RED: begin
        md_req.a = MD_W'(pb);
        md_req.b = lt200k ? MD_W'(TIMER_BITS'(PITCH_ATTACK_US) - timer) : '0;
        md_req.d = MD_W'(PITCH_ATTACK_US);
      end
      ST_VY: begin
        md_req.a = MD_W'(last_y);
        md_req.b = MD_W'(VOL_MAX);
        md_req.d = MD_W'(TOUCH_MAX);
      end
      ST_VOL: begin
        md_req.d = MD_W'(VOL_FADE_US);
        if (held_octave != 3'd0) begin
          md_req.a = MD_W'(vfloor);
          md_req.b = lt100k ? MD_W'(timer) : MD_W'(VOL_FADE_US);
        end else begin
          md_req.a = MD_W'(vy);
          md_req.b = lt100k ? MD_W'(TIMER_BITS'(VOL_FADE_US) - timer) : '0;
        end
      end
      ST_FLUSH: begin
        if (le1m)      md_req.a = MD_W'(FLUSH_SPAN_US);
        else if (ge7m) md_req.a = '0;
        else           md_req.a = MD_W'(TIMER_BITS'(FLUSH_END_US) - timer);
        md_req.b = MD_W'(FLUSH_ONE);
        md_req.d = MD_W'(FLUSH_SPAN_US);
      end
      ST_CHEEK: begin
        md_req.a = MD_W'(vol);
        md_req.b = MD_W'(flush_rate);
        md_req.d = MD_W'(FLUSH_ONE);
      end
      default: begin
        md_req.a = '0;
      end
    endcase
  end

  npve_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  always_comb begin
    state_next  = state;
    launch_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next  = ST_HZ;
          launch_next = 1'b1;
        end
      end
      ST_HZ: begin
        if (md_rsp.done) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (si == 4'(NOTE_COUNT - 1)) begin
          state_next  = ST_FDIV;
          launch_next = 1'b1;
        end
      end
      ST_FDIV: begin
        if (md_rsp.done) begin
          state_next  = ST_PB;
          launch_next = 1'b1;
        end
      end
      ST_PB: begin
        if (md_rsp.done) begin
          state_next  = ST_RED;
          launch_next = 1'b1;
        end
      end
      ST_RED: begin
        if (md_rsp.done) begin
          state_next  = ST_VY;
          launch_next = 1'b1;
        end
      end
      ST_VY: begin
        if (md_rsp.done) begin
          state_next  = ST_VOL;
          launch_next = 1'b1;
        end
      end
      ST_VOL: begin
        if (md_rsp.done) begin
          state_next  = ST_FLUSH;
          launch_next = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (md_rsp.done) begin
          state_next  = ST_CHEEK;
          launch_next = 1'b1;
        end
      end
      ST_CHEEK: begin
        if (md_rsp.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer       <= TIMER_BITS'(VOL_FADE_US);
      held_octave <= 3'd0;
      last_x      <= 10'd512;
      last_y      <= 10'd512;
      last_freq   <= 11'd0;
      flush_rate  <= 9'd0;
    end else begin
      if (accept) begin
        if (in_oct != held_octave) begin
          timer       <= '0;
          held_octave <= in_oct;
        end else begin
          timer <= tsat;
        end
        if (s_tdata[24]) begin
          last_x <= s_tdata[34:25];
          last_y <= s_tdata[44:35];
        end
      end
      if (state == ST_RED && md_rsp.done && held_octave != 3'd0) begin
        last_freq <= (red >= fshift) ? 11'd0 : fshift - red;
      end
      if (state == ST_FLUSH && md_rsp.done && held_octave != 3'd0) begin
        flush_rate <= md_rsp.q[8:0];
      end
    end
  end

  // Working values and output registers; the search takes one table entry per cycle.
  always_ff @(posedge clk) begin
    case (state)
      ST_HZ: begin
        if (md_rsp.done) begin
          hz   <= 8'(md_rsp.q[7:0] + 8'(HZ_BASE));
          best <= 8'd0;
          idx  <= 4'(NOTE_COUNT);
          si   <= 4'd0;
        end
      end
      ST_SEARCH: begin
        if (d_new < d_best) begin
          best <= tv;
          idx  <= si;
        end
        si <= si + 4'd1;
      end
      ST_FDIV:  if (md_rsp.done) fdiv <= md_rsp.q[3:0];
      ST_PB:    if (md_rsp.done) pb   <= md_rsp.q[10:0];
      ST_VY:    if (md_rsp.done) vy   <= md_rsp.q[7:0];
      ST_VOL:   if (md_rsp.done) vol  <= md_rsp.q[7:0];
      ST_CHEEK: if (md_rsp.done) cheek <= md_rsp.q[7:0];
      ST_OUT: begin
        if (out_load) begin
          o_freq  <= last_freq;
          o_vol   <= vol;
          o_idx   <= (held_octave != 3'd0) ? idx : 4'(NOTE_COUNT);
          o_oct   <= held_octave;
          o_cheek <= cheek;
        end
      end
      default: begin
        si <= si;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {6'd0, o_cheek, o_oct, o_idx, o_vol, o_freq};

  a_none_means_rest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_oct == 3'd0 |-> o_idx == 4'(NOTE_COUNT))
    else $error("note index set while no octave held");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in work");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    md_req.start |-> !md_rsp.busy)
    else $error("unit started while busy");

  a_octave_range: assert property (@(posedge clk) disable iff (rst)
    held_octave <= 3'd4)
    else $error("held octave out of range");

  a_done_in_op: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> state != ST_IDLE && state != ST_SEARCH && state != ST_OUT)
    else $error("unit result arrived with no operation pending");

endmodule
